/* src/aesc_pkg.sv */
`default_nettype none
package aesc_pkg;

    localparam int RoundKeyWords = 60;
    localparam int MaxRounds     = 14;
    localparam int NumStages     = MaxRounds + 1;

    localparam logic [1:0] KEY_128  = 2'd0;
    localparam logic [1:0] KEY_192  = 2'd1;
    localparam logic [1:0] KEY_256  = 2'd2;
    localparam logic [1:0] KEY_RSVD = 2'd3;

    localparam logic [2:0] CFG_KEY_SIZE  = 3'd0;
    localparam logic [2:0] CFG_KEY_WORD0 = 3'd1;
    localparam logic [2:0] CFG_KEY_WORD1 = 3'd2;
    localparam logic [2:0] CFG_KEY_WORD2 = 3'd3;
    localparam logic [2:0] CFG_KEY_WORD3 = 3'd4;

    typedef logic [7:0]  byte_t;
    typedef logic [31:0] rk_word_t;

    typedef struct packed {
        logic         vld;
        logic [127:0] st;
        logic [63:0]  d0;
        logic [63:0]  d1;
        logic [4:0]   vb;
    } cell_t;

    localparam byte_t SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    function automatic byte_t xtime(input byte_t x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic rk_word_t sbox_word(input rk_word_t w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // rounds for a key size code, code 3 runs as 256-bit
    function automatic logic [3:0] num_rounds(input logic [1:0] ks);
        case (ks)
            KEY_128: return 4'd10;
            KEY_192: return 4'd12;
            default: return 4'd14;
        endcase
    endfunction

endpackage
`default_nettype wire

/* src/aesc_key_sched.sv */
`default_nettype none
module aesc_key_sched
    import aesc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       start_i,
    input  wire logic [1:0] key_size_i,
    input  wire logic [63:0] key_word0_i,
    input  wire logic [63:0] key_word1_i,
    input  wire logic [63:0] key_word2_i,
    input  wire logic [63:0] key_word3_i,
    output logic            busy_o,
    output rk_word_t        rk_o [RoundKeyWords]
);

    rk_word_t   rk_reg  [RoundKeyWords];
    rk_word_t   win_reg [8];
    logic [5:0] idx_reg;
    logic [2:0] phase_reg;
    byte_t      rc_reg;
    logic       run_reg;

    rk_word_t   kw [8];
    logic [3:0] nk;
    logic [5:0] total;
    rk_word_t   tap;
    rk_word_t   t;
    rk_word_t   word_next;

    assign kw[0] = key_word0_i[63:32];
    assign kw[1] = key_word0_i[31:0];
    assign kw[2] = key_word1_i[63:32];
    assign kw[3] = key_word1_i[31:0];
    assign kw[4] = key_word2_i[63:32];
    assign kw[5] = key_word2_i[31:0];
    assign kw[6] = key_word3_i[63:32];
    assign kw[7] = key_word3_i[31:0];

    always_comb begin
        nk    = num_rounds(key_size_i) - 4'd6;
        total = {nk, 2'b00} + 6'd28;
        tap   = win_reg[nk[2:0] - 3'd1];
        t     = win_reg[0];
        if (phase_reg == 3'd0) begin
            t = sbox_word({win_reg[0][23:0], win_reg[0][31:24]}) ^ {rc_reg, 24'h0};
        end else if (nk == 4'd8 && phase_reg == 3'd4) begin
            t = sbox_word(win_reg[0]);
        end
        word_next = tap ^ t;
    end

    always_ff @(posedge aclk) begin
        if (start_i) begin
            for (int k = 0; k < 8; k++) begin
                rk_reg[k] <= kw[k];
                if (k < int'(nk)) begin
                    win_reg[k] <= kw[3'(int'(nk) - 1 - k)];
                end
            end
            idx_reg   <= {2'b00, nk};
            phase_reg <= 3'd0;
            rc_reg    <= 8'h01;
        end else if (run_reg) begin
            rk_reg[idx_reg] <= word_next;
            win_reg[0]      <= word_next;
            for (int k = 1; k < 8; k++) begin
                win_reg[k] <= win_reg[k-1];
            end
            idx_reg   <= idx_reg + 6'd1;
            phase_reg <= (phase_reg == nk[2:0] - 3'd1) ? 3'd0 : phase_reg + 3'd1;
            if (phase_reg == 3'd0) begin
                rc_reg <= xtime(rc_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
        end else if (start_i) begin
            run_reg <= 1'b1;
        end else if (run_reg && idx_reg == total - 6'd1) begin
            run_reg <= 1'b0;
        end
    end

    assign busy_o = run_reg;
    assign rk_o   = rk_reg;

endmodule
`default_nettype wire

/* src/aesc_round_cell.sv */
`default_nettype none
module aesc_round_cell
    import aesc_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         en_i,
    input  wire logic [3:0]   rnd_i,
    input  wire logic [3:0]   nr_i,
    input  wire logic [127:0] rkey_i,
    input  wire cell_t        cell_i,
    output cell_t             cell_o
);

    cell_t  cell_reg;
    cell_t  cell_next;
    byte_t  s [16];
    byte_t  sb [16];
    byte_t  mx [16];
    byte_t  all;
    logic [127:0] rnd_out;

    always_comb begin
        for (int k = 0; k < 16; k++) begin
            s[k] = cell_i.st[127 - 8*k -: 8];
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                sb[4*c + r] = SBOX[s[4*((c + r) % 4) + r]];
            end
        end
        for (int c = 0; c < 4; c++) begin
            all = sb[4*c] ^ sb[4*c+1] ^ sb[4*c+2] ^ sb[4*c+3];
            for (int r = 0; r < 4; r++) begin
                mx[4*c + r] = (rnd_i == nr_i) ? sb[4*c + r]
                    : sb[4*c + r] ^ all ^ xtime(sb[4*c + r] ^ sb[4*c + (r + 1) % 4]);
            end
        end
        for (int k = 0; k < 16; k++) begin
            rnd_out[127 - 8*k -: 8] = mx[k];
        end
        cell_next = cell_i;
        if (rnd_i <= nr_i) begin
            cell_next.st = rnd_out ^ rkey_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.vld <= 1'b0;
        end else if (en_i) begin
            cell_reg.vld <= cell_next.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_i) begin
            cell_reg.st <= cell_next.st;
            cell_reg.d0 <= cell_next.d0;
            cell_reg.d1 <= cell_next.d1;
            cell_reg.vb <= cell_next.vb;
        end
    end

    assign cell_o = cell_reg;

endmodule
`default_nettype wire

/* src/aes_ctr_stream_cipher_core.sv */
// channel  | handshake          | content
// s_       | s_valid / s_ready  | data halves, valid_bytes
// m_       | m_valid / m_ready  | processed halves, out_valid_bytes
// cfg_     | cfg_valid/cfg_ready| register index, write data
// one block per cycle unless a held result or the key schedule stalls it; entry stage plus 14 round cells
// short keys pass through the unused trailing cells, so latency is the same for all key sizes
// each key size or key word write reruns the key schedule, a start pulse then one round key word
// per cycle, with s_ready low throughout; configuration is always ready
// a stalled result freezes the whole cell chain; reset clears valids and the counter
`default_nettype none
module aes_ctr_stream_cipher_core
    import aesc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [63:0] s_data_first_half,
    input  wire logic [63:0] s_data_second_half,
    input  wire logic [4:0]  s_valid_bytes,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [63:0]      m_out_first_half,
    output logic [63:0]      m_out_second_half,
    output logic [4:0]       m_out_valid_bytes,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);

    logic [1:0]  key_size_reg;
    logic [63:0] key_word0_reg;
    logic [63:0] key_word1_reg;
    logic [63:0] key_word2_reg;
    logic [63:0] key_word3_reg;
    logic [63:0] ctr_reg;
    logic [63:0] ctr_next;
    logic        start_reg;
    logic        ks_busy;
    logic        cfg_hit;
    logic        en;
    logic        s_take;
    logic [3:0]  nr;
    logic [4:0]  vb_sat;
    logic [127:0] blk;
    logic [63:0] mask0;
    logic [63:0] mask1;
    rk_word_t    rk [RoundKeyWords];
    cell_t       entry_reg;
    cell_t       chain [NumStages];

    assign cfg_ready = 1'b1;
    assign cfg_hit   = cfg_valid && (cfg_index == CFG_KEY_SIZE || cfg_index == CFG_KEY_WORD0 ||
        cfg_index == CFG_KEY_WORD1 || cfg_index == CFG_KEY_WORD2 || cfg_index == CFG_KEY_WORD3);
    assign en        = !chain[MaxRounds].vld || m_ready;
    assign s_ready   = en && !ks_busy && !start_reg;
    assign s_take    = s_valid && s_ready;
    assign nr        = num_rounds(key_size_reg);
    assign ctr_next  = ctr_reg + 64'd1;
    assign vb_sat    = (s_valid_bytes > 5'd16) ? 5'd16 : s_valid_bytes;

    always_comb begin
        blk = '0;
        for (int i = 0; i < 8; i++) begin
            blk[127 - 8*i -: 8] = ctr_next[8*i +: 8];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_size_reg  <= KEY_128;
            key_word0_reg <= '0;
            key_word1_reg <= '0;
            key_word2_reg <= '0;
            key_word3_reg <= '0;
            ctr_reg       <= '0;
            start_reg     <= 1'b0;
        end else begin
            start_reg <= cfg_hit;
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_KEY_SIZE:  key_size_reg  <= cfg_data[1:0];
                    CFG_KEY_WORD0: key_word0_reg <= cfg_data;
                    CFG_KEY_WORD1: key_word1_reg <= cfg_data;
                    CFG_KEY_WORD2: key_word2_reg <= cfg_data;
                    CFG_KEY_WORD3: key_word3_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cfg_hit) begin
                ctr_reg <= '0;
            end else if (s_take && vb_sat != 5'd0) begin
                ctr_reg <= ctr_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg.vld <= 1'b0;
        end else if (en) begin
            entry_reg.vld <= s_take;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            entry_reg.st <= blk ^ {rk[0], rk[1], rk[2], rk[3]};
            entry_reg.d0 <= s_data_first_half;
            entry_reg.d1 <= s_data_second_half;
            entry_reg.vb <= vb_sat;
        end
    end

    aesc_key_sched u_key_sched (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start_i     (start_reg),
        .key_size_i  (key_size_reg),
        .key_word0_i (key_word0_reg),
        .key_word1_i (key_word1_reg),
        .key_word2_i (key_word2_reg),
        .key_word3_i (key_word3_reg),
        .busy_o      (ks_busy),
        .rk_o        (rk)
    );

    assign chain[0] = entry_reg;

    for (genvar r = 1; r <= MaxRounds; r++) begin : g_cell
        aesc_round_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en_i    (en),
            .rnd_i   (4'(r)),
            .nr_i    (nr),
            .rkey_i  ({rk[4*r], rk[4*r+1], rk[4*r+2], rk[4*r+3]}),
            .cell_i  (chain[r-1]),
            .cell_o  (chain[r])
        );
    end

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            mask0[63 - 8*k -: 8] = (5'(k) < chain[MaxRounds].vb) ? 8'hff : 8'h00;
            mask1[63 - 8*k -: 8] = (5'(k + 8) < chain[MaxRounds].vb) ? 8'hff : 8'h00;
        end
    end

    assign m_valid           = chain[MaxRounds].vld;
    assign m_out_first_half  = (chain[MaxRounds].d0 ^ chain[MaxRounds].st[127:64]) & mask0;
    assign m_out_second_half = (chain[MaxRounds].d1 ^ chain[MaxRounds].st[63:0]) & mask1;
    assign m_out_valid_bytes = chain[MaxRounds].vb;

    a_ctr_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_hit |=> ctr_reg == 64'd0)
        else $error("counter not cleared by key write");

    a_no_take_in_sched: assert property (@(posedge aclk) disable iff (!aresetn)
        (ks_busy || start_reg) |-> !s_take)
        else $error("request taken during key schedule");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(chain[MaxRounds].st))
        else $error("stalled result changed");

    a_vb_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_out_valid_bytes <= 5'd16)
        else $error("byte count out of range");

endmodule
`default_nettype wire
